// ----- src/dtt_pkg.sv -----
package dtt_pkg;

  // slot numbers are carried at this width in the command and the search token; the ports carry them in 4 bits
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned MAX_EXPIRE  = 16;
  localparam logic [31:0] WINDOW_RST  = 32'd3600000;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_CANCEL  = 3'd1,
    OP_REFRESH = 3'd2,
    OP_RESET   = 3'd3,
    OP_WAIT    = 3'd4,
    OP_COLLECT = 3'd5,
    OP_ANY     = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_ADD,
    CMD_CANCEL,
    CMD_REFRESH,
    CMD_RESET,
    CMD_PICK,
    CMD_CLRPICK
  } cmd_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_EVAL,
    S_OUT
  } state_t;

  typedef struct packed {
    cmd_code_t         code;
    logic [SLOT_W-1:0] id;
    logic [63:0]       val;
    logic              rep;
    logic              fnow;
    logic [63:0]       now;
  } cmd_t;

  typedef struct packed {
    logic              found;
    logic [63:0]       deadline;
    logic [SLOT_W-1:0] id;
  } token_t;

endpackage

// ----- src/deadline_timer_table_unit.sv -----
// deadline timer table: NUM_TIMERS timer slots kept in a row of cells, one slot per cell.
// a search token walks the row one cell per cycle to find the earliest (or the earliest
// due) slot. cancel, refresh, any-active, rejected commands, a reset that keeps its
// period and a collect with no active slot answer without a search of the row; add,
// reset and next-wait search it once. collect searches it again after each expired
// slot it takes (at most 16 per collect) and gives one result word per expired slot,
// or one word when nothing is due. a result word held by out_stall holds the block.
// one word is in flight at a time: in_stall stays high until the last result word is taken.
// register 0 at byte address 0 is the 32-bit rollover window in milliseconds.
module deadline_timer_table_unit #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // command words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [3:0]  in_timer_id,
  input  logic [63:0] in_interval_ms,
  input  logic        in_repeat_mode,
  input  logic        in_from_now,
  input  logic [63:0] in_now_ms,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic        out_new_first,
  output logic        out_has_expiry,
  output logic [3:0]  out_expired_id,
  output logic [63:0] out_wait_ms,
  output logic        out_last,
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import dtt_pkg::*;

  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW = $clog2(NUM_TIMERS + 1);
  localparam int unsigned NW = $clog2(MAX_EXPIRE + 1);

  state_t state_r, state_nxt;

  // latched command word
  op_t         op_r;
  logic [3:0]  id_r;
  logic [63:0] ival_r;
  logic        rep_r;
  logic        fnow_r;
  logic [63:0] now_r;

  // control state
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic              pend_r, pend_nxt;
  logic [SLOT_W-1:0] pend_id_r, pend_id_nxt;
  logic              cont_r, cont_nxt;
  logic              tickled_r, tickled_nxt;
  logic              roll_r, roll_nxt;
  logic [63:0]       prev_r, prev_nxt;
  logic [31:0]       window_r;

  // result word register
  logic              out_valid_r;
  logic              o_ok_r, o_front_r, o_hx_r, o_last_r;
  logic [3:0]        o_id_r;
  logic [63:0]       o_wait_r;
  logic              load;
  logic              o_ok, o_front, o_hx, o_last;
  logic [SLOT_W-1:0] o_id;
  logic [63:0]       o_wait;

  // cell row
  cmd_t        cmd;
  token_t      tok [NUM_TIMERS+1];
  logic        active_v [NUM_TIMERS];
  logic [63:0] period_v [NUM_TIMERS];
  logic        due_only;
  token_t      tail;

  // decisions shared by the two fsm blocks
  logic          id_ok, sel_active, early, any_act, pick_now, go_scan, front;
  logic [IW-1:0] id_ix;
  logic [63:0]   sel_period;
  logic [63:0]   prev_minus;

  assign id_ix      = IW'(id_r);
  assign id_ok      = (32'(id_r) < NUM_TIMERS);
  assign sel_active = active_v[id_ix];
  assign sel_period = period_v[id_ix];
  assign early      = (ival_r == sel_period) && !fnow_r;
  assign tail       = tok[NUM_TIMERS];
  assign due_only   = (op_r == OP_COLLECT);
  assign pick_now   = tail.found && (32'(n_r) < MAX_EXPIRE);
  assign front      = tail.found && (tail.id == SLOT_W'(id_r)) && !tickled_r;
  assign prev_minus = prev_r - {32'd0, window_r};

  always_comb begin
    any_act = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      any_act = any_act | active_v[i];
    end
  end

  // commands that need a search of the row
  always_comb begin
    case (op_r)
      OP_ADD:     go_scan = id_ok;
      OP_RESET:   go_scan = id_ok && !early && sel_active;
      OP_WAIT:    go_scan = 1'b1;
      OP_COLLECT: go_scan = any_act;
      default:    go_scan = 1'b0;
    endcase
  end

  // the search token enters the row empty
  assign tok[0] = '0;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    dtt_cell #(
      .CELL_ID (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd_i      (cmd),
      .due_only_i (due_only),
      .roll_i     (roll_r),
      .tok_i      (tok[g]),
      .tok_o      (tok[g+1]),
      .active_o   (active_v[g]),
      .period_o   (period_v[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: state_nxt = go_scan ? S_SCAN : S_OUT;
      S_SCAN:   if (32'(cnt_r) == NUM_TIMERS - 1) state_nxt = S_EVAL;
      S_EVAL: begin
        // first pick of a collect goes straight back to search for the next one
        if (op_r == OP_COLLECT && pick_now && !pend_r) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT:    if (!out_stall) state_nxt = cont_r ? S_SCAN : S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    cmd.code    = CMD_NONE;
    cmd.id      = SLOT_W'(id_r);
    cmd.val     = ival_r;
    cmd.rep     = rep_r;
    cmd.fnow    = fnow_r;
    cmd.now     = now_r;
    load        = 1'b0;
    o_ok        = 1'b0;
    o_front     = 1'b0;
    o_hx        = 1'b0;
    o_id        = '0;
    o_wait      = '0;
    o_last      = 1'b1;
    cnt_nxt     = '0;
    n_nxt       = n_r;
    pend_nxt    = pend_r;
    pend_id_nxt = pend_id_r;
    cont_nxt    = cont_r;
    tickled_nxt = tickled_r;
    roll_nxt    = roll_r;
    prev_nxt    = prev_r;
    unique case (state_r)
      S_DECODE: begin
        case (op_r)
          OP_ADD: begin
            if (id_ok) cmd.code = CMD_ADD;
            else load = 1'b1;
          end
          OP_CANCEL: begin
            load = 1'b1;
            if (id_ok && sel_active) begin
              cmd.code = CMD_CANCEL;
              o_ok     = 1'b1;
            end
          end
          OP_REFRESH: begin
            load = 1'b1;
            if (id_ok && sel_active) begin
              cmd.code = CMD_REFRESH;
              o_ok     = 1'b1;
            end
          end
          OP_RESET: begin
            if (!id_ok) begin
              load = 1'b1;
            end else if (early) begin
              // same period counted from the old start changes nothing
              load = 1'b1;
              o_ok = 1'b1;
            end else if (sel_active) begin
              cmd.code = CMD_RESET;
            end else begin
              load = 1'b1;
            end
          end
          OP_WAIT: tickled_nxt = 1'b0;
          OP_COLLECT: begin
            if (!any_act) begin
              load = 1'b1;
              o_ok = 1'b1;
            end else begin
              // backward jump past the window expires every slot
              roll_nxt = (now_r < prev_r) && (now_r < prev_minus);
              prev_nxt = now_r;
              cmd.code = CMD_CLRPICK;
              n_nxt    = '0;
              pend_nxt = 1'b0;
            end
          end
          OP_ANY: begin
            load = 1'b1;
            o_ok = any_act;
          end
          default: load = 1'b1;
        endcase
        if (load) cont_nxt = 1'b0;
      end
      S_SCAN: cnt_nxt = cnt_r + CW'(1);
      S_EVAL: begin
        case (op_r)
          OP_ADD, OP_RESET: begin
            load     = 1'b1;
            o_ok     = 1'b1;
            o_front  = front;
            cont_nxt = 1'b0;
            if (front) tickled_nxt = 1'b1;
          end
          OP_WAIT: begin
            load     = 1'b1;
            o_ok     = 1'b1;
            cont_nxt = 1'b0;
            if (!tail.found) o_wait = '1;
            else if (now_r >= tail.deadline) o_wait = '0;
            else o_wait = tail.deadline - now_r;
          end
          OP_COLLECT: begin
            o_ok = 1'b1;
            // slot number only rides along with an expiry
            o_id = pend_r ? pend_id_r : '0;
            o_hx = pend_r;
            if (pick_now) begin
              // rearm or retire the slot at once, its picked mark keeps it out
              cmd.code    = CMD_PICK;
              cmd.id      = tail.id;
              n_nxt       = n_r + NW'(1);
              pend_nxt    = 1'b1;
              pend_id_nxt = tail.id;
              if (pend_r) begin
                load     = 1'b1;
                o_last   = 1'b0;
                cont_nxt = 1'b1;
              end
            end else begin
              load     = 1'b1;
              cont_nxt = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      n_r         <= '0;
      pend_r      <= 1'b0;
      pend_id_r   <= '0;
      cont_r      <= 1'b0;
      tickled_r   <= 1'b0;
      roll_r      <= 1'b0;
      prev_r      <= '0;
      window_r    <= WINDOW_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      n_r       <= n_nxt;
      pend_r    <= pend_nxt;
      pend_id_r <= pend_id_nxt;
      cont_r    <= cont_nxt;
      tickled_r <= tickled_nxt;
      roll_r    <= roll_nxt;
      prev_r    <= prev_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
        window_r <= cfg_pwdata;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // command word and result word payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r   <= op_t'(in_operation);
      id_r   <= in_timer_id;
      ival_r <= in_interval_ms;
      rep_r  <= in_repeat_mode;
      fnow_r <= in_from_now;
      now_r  <= in_now_ms;
    end
    if (load) begin
      o_ok_r    <= o_ok;
      o_front_r <= o_front;
      o_hx_r    <= o_hx;
      o_id_r    <= 4'(o_id);
      o_wait_r  <= o_wait;
      o_last_r  <= o_last;
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_ok         = o_ok_r;
  assign out_new_first  = o_front_r;
  assign out_has_expiry = o_hx_r;
  assign out_expired_id = o_id_r;
  assign out_wait_ms    = o_wait_r;
  assign out_last       = o_last_r;
  assign cfg_pready     = 1'b1;
  assign cfg_prdata     = cfg_paddr[2] ? 32'd0 : window_r;

endmodule

// ----- src/dtt_cell.sv -----
module dtt_cell #(
  parameter int unsigned CELL_ID = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dtt_pkg::cmd_t   cmd_i,
  input  logic            due_only_i,
  input  logic            roll_i,
  input  dtt_pkg::token_t tok_i,
  output dtt_pkg::token_t tok_o,
  output logic            active_o,
  output logic [63:0]     period_o
);
  import dtt_pkg::*;

  logic [63:0] deadline_r, deadline_nxt;
  logic [63:0] period_r, period_nxt;
  logic        rearm_r, rearm_nxt;
  logic        active_r, active_nxt;
  logic        picked_r, picked_nxt;
  token_t      tok_r, tok_nxt;
  logic        hit, cand, take;
  logic [63:0] start;

  assign hit   = (cmd_i.id == SLOT_W'(CELL_ID));
  assign start = cmd_i.fnow ? cmd_i.now : (deadline_r - period_r);

  always_comb begin
    deadline_nxt = deadline_r;
    period_nxt   = period_r;
    rearm_nxt    = rearm_r;
    active_nxt   = active_r;
    picked_nxt   = picked_r;
    case (cmd_i.code)
      CMD_ADD: if (hit) begin
        deadline_nxt = cmd_i.now + cmd_i.val;
        period_nxt   = cmd_i.val;
        rearm_nxt    = cmd_i.rep;
        active_nxt   = 1'b1;
      end
      CMD_CANCEL: if (hit) begin
        active_nxt = 1'b0;
      end
      CMD_REFRESH: if (hit) begin
        deadline_nxt = cmd_i.now + period_r;
      end
      CMD_RESET: if (hit) begin
        period_nxt   = cmd_i.val;
        deadline_nxt = start + cmd_i.val;
      end
      CMD_PICK: if (hit) begin
        picked_nxt = 1'b1;
        if (rearm_r) begin
          deadline_nxt = cmd_i.now + period_r;
        end else begin
          active_nxt = 1'b0;
        end
      end
      CMD_CLRPICK: picked_nxt = 1'b0;
      default: ;
    endcase
  end

  // compare this slot with the best one handed in from the lower slots
  always_comb begin
    cand = active_r &&
           (!due_only_i || (!picked_r && (roll_i || deadline_r <= cmd_i.now)));
    take = cand && (!tok_i.found || deadline_r < tok_i.deadline);
    if (take) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.deadline = deadline_r;
      tok_nxt.id       = SLOT_W'(CELL_ID);
    end else begin
      tok_nxt = tok_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      picked_r <= 1'b0;
      tok_r    <= '0;
    end else begin
      active_r <= active_nxt;
      picked_r <= picked_nxt;
      tok_r    <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deadline_r <= deadline_nxt;
    period_r   <= period_nxt;
    rearm_r    <= rearm_nxt;
  end

  assign tok_o    = tok_r;
  assign active_o = active_r;
  assign period_o = period_r;

endmodule

// ----- sim/deadline_timer_table_unit_tb.sv -----
`default_nettype none

module deadline_timer_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dtt_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam logic [2:0] OP_UNDEF = 3'd7;          // no such operation, must be rejected
  localparam logic [2:0] ADDR_WINDOW = 3'd0;       // rollover window register
  localparam int unsigned STALL_LIMIT = 20000;     // cycles with no word moving on either side
  localparam int unsigned DRAIN_CYCLES = 400;      // settling time after the last word
  localparam logic [63:0] ALL_ONES = '1;

  typedef struct {
    logic [2:0]  op;
    logic [3:0]  id;
    logic [63:0] ivl;
    logic        rep;
    logic        fnow;
    logic [63:0] now;
  } cmd_word_t;

  typedef struct {
    logic        ok;
    logic        front;
    logic        hx;
    logic [3:0]  xid;
    logic [63:0] wait_ms;
    logic        last;
  } result_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_operation = '0;
  logic [3:0]  in_timer_id = '0;
  logic [63:0] in_interval_ms = '0;
  logic        in_repeat_mode = 1'b0;
  logic        in_from_now = 1'b0;
  logic [63:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ok;
  logic        out_new_first;
  logic        out_has_expiry;
  logic [3:0]  out_expired_id;
  logic [63:0] out_wait_ms;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  deadline_timer_table_unit #(.NUM_TIMERS(SLOTS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_timer_id(in_timer_id), .in_interval_ms(in_interval_ms),
    .in_repeat_mode(in_repeat_mode), .in_from_now(in_from_now), .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_stall(out_stall), .out_ok(out_ok),
    .out_new_first(out_new_first), .out_has_expiry(out_has_expiry),
    .out_expired_id(out_expired_id), .out_wait_ms(out_wait_ms), .out_last(out_last),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // timer table mirror: slot state as the block should hold it
  // ---------------------------------------------------------------------------
  logic [63:0] tbl_deadline [SLOTS];
  logic [63:0] tbl_period [SLOTS];
  logic        tbl_rearm [SLOTS];
  logic        tbl_active [SLOTS];
  logic        tbl_tickled;
  logic [63:0] tbl_prev_now;
  logic [31:0] tbl_window;

  result_word_t due_words [$];   // result words still to come from the block
  cmd_word_t    cmd_backlog [$]; // command words not yet offered

  int unsigned n_cmds, n_words, n_expired, n_rollovers, n_mismatch;
  logic        sender_idles, receiver_idles;

  // slot a sorts ahead of slot b: by deadline, ties broken by slot number
  function automatic logic slot_precedes(int a, int b);
    if (tbl_deadline[a] != tbl_deadline[b]) return tbl_deadline[a] < tbl_deadline[b];
    return a < b;
  endfunction

  // earliest active slot, SLOTS when the table is empty
  function automatic int earliest_slot();
    int best;
    best = SLOTS;
    for (int i = 0; i < SLOTS; i++)
      if (tbl_active[i] && (best == SLOTS || slot_precedes(i, best))) best = i;
    return best;
  endfunction

  // front report fires only once until a next-wait query clears the tickle
  function automatic logic claims_front(int id);
    logic f;
    f = (earliest_slot() == id) && !tbl_tickled;
    if (f) tbl_tickled = 1'b1;
    return f;
  endfunction

  function automatic void push_word(logic ok, logic front, logic hx, logic [3:0] xid,
                                    logic [63:0] w, logic last);
    result_word_t r;
    r.ok = ok; r.front = front; r.hx = hx; r.xid = xid; r.wait_ms = w; r.last = last;
    due_words = {due_words, r};
  endfunction

  // apply one accepted command to the mirror and queue the words it should yield
  function automatic void apply_timer_cmd(cmd_word_t c);
    int id, e, best, n;
    logic ok, front, roll;
    logic [63:0] start, w;
    logic picked [SLOTS];
    int order [$];
    id = c.id;
    ok = 1'b0;
    front = 1'b0;
    case (c.op)
      OP_ADD: begin
        tbl_period[id] = c.ivl;
        tbl_rearm[id] = c.rep;
        tbl_deadline[id] = c.now + c.ivl;
        tbl_active[id] = 1'b1;
        front = claims_front(id);
        ok = 1'b1;
      end
      OP_CANCEL: begin
        if (tbl_active[id]) begin
          tbl_active[id] = 1'b0;
          ok = 1'b1;
        end
      end
      OP_REFRESH: begin
        if (tbl_active[id]) begin
          tbl_deadline[id] = c.now + tbl_period[id];
          ok = 1'b1;
        end
      end
      OP_RESET: begin
        // same period counted from the old start changes nothing, active or not
        if (c.ivl == tbl_period[id] && !c.fnow) ok = 1'b1;
        else if (tbl_active[id]) begin
          start = c.fnow ? c.now : tbl_deadline[id] - tbl_period[id];
          tbl_period[id] = c.ivl;
          tbl_deadline[id] = start + c.ivl;
          front = claims_front(id);
          ok = 1'b1;
        end
      end
      OP_WAIT: begin
        tbl_tickled = 1'b0;
        e = earliest_slot();
        if (e == SLOTS) w = ALL_ONES;
        else if (c.now >= tbl_deadline[e]) w = '0;
        else w = tbl_deadline[e] - c.now;
        push_word(1'b1, 1'b0, 1'b0, '0, w, 1'b1);
        return;
      end
      OP_COLLECT: begin
        if (earliest_slot() == SLOTS) begin
          push_word(1'b1, 1'b0, 1'b0, '0, '0, 1'b1);
          return;
        end
        // backward jump past the window, wrapping below zero, expires everything
        roll = c.now < tbl_prev_now && c.now < tbl_prev_now - {32'd0, tbl_window};
        if (roll) n_rollovers++;
        tbl_prev_now = c.now;
        foreach (picked[i]) picked[i] = 1'b0;
        while (order.size() < MAX_EXPIRE) begin
          best = SLOTS;
          for (int i = 0; i < SLOTS; i++)
            if (tbl_active[i] && !picked[i] && (roll || tbl_deadline[i] <= c.now) &&
                (best == SLOTS || slot_precedes(i, best))) best = i;
          if (best == SLOTS) break;
          picked[best] = 1'b1;
          order = {order, best};
        end
        n = order.size();
        if (n == 0) begin
          push_word(1'b1, 1'b0, 1'b0, '0, '0, 1'b1);
          return;
        end
        for (int k = 0; k < n; k++) begin
          if (tbl_rearm[order[k]]) tbl_deadline[order[k]] = c.now + tbl_period[order[k]];
          else tbl_active[order[k]] = 1'b0;
          push_word(1'b1, 1'b0, 1'b1, 4'(order[k]), '0, k == n - 1);
        end
        return;
      end
      OP_ANY: ok = earliest_slot() != SLOTS;
      default: ok = 1'b0;
    endcase
    push_word(ok, front, 1'b0, '0, '0, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // command driver: bursts of words with random gaps
  // ---------------------------------------------------------------------------
  cmd_word_t   cur_cmd;
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;

  always @(posedge clk) begin
    logic offer;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_timer_cmd(cur_cmd);
        n_cmds++;
      end
      // payload only moves when nothing is held or the held word was just taken
      if (!in_valid || !in_stall) begin
        offer = 1'b0;
        if (gap_left > 0) gap_left--;
        else if (cmd_backlog.size() > 0) begin
          offer = 1'b1;
          cur_cmd = cmd_backlog.pop_front();
          if (--burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left = sender_idles ? $urandom_range(0, 12) : 0;
          end
        end
        in_valid <= offer;
        if (offer) begin
          in_operation <= cur_cmd.op;
          in_timer_id <= cur_cmd.id;
          in_interval_ms <= cur_cmd.ivl;
          in_repeat_mode <= cur_cmd.rep;
          in_from_now <= cur_cmd.fnow;
          in_now_ms <= cur_cmd.now;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor, receiver stall runs and watchdog
  // ---------------------------------------------------------------------------
  int unsigned stall_run = 0;
  logic        stall_next = 1'b0;
  int unsigned quiet_cycles = 0;

  task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    result_word_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_words++;
        if (out_has_expiry) n_expired++;
        if (due_words.size() == 0) flag_mismatch("unexpected result word", '0, 64'd1);
        else begin
          e = due_words.pop_front();
          if (out_ok !== e.ok) flag_mismatch("ok", 64'(e.ok), 64'(out_ok));
          if (out_new_first !== e.front)
            flag_mismatch("new_first", 64'(e.front), 64'(out_new_first));
          if (out_has_expiry !== e.hx)
            flag_mismatch("has_expiry", 64'(e.hx), 64'(out_has_expiry));
          if (out_expired_id !== e.xid)
            flag_mismatch("expired_id", 64'(e.xid), 64'(out_expired_id));
          if (out_wait_ms !== e.wait_ms) flag_mismatch("wait_ms", e.wait_ms, out_wait_ms);
          if (out_last !== e.last) flag_mismatch("last", 64'(e.last), 64'(out_last));
        end
      end
      // stall in runs of random length, on or off
      if (stall_run == 0) begin
        stall_run = $urandom_range(1, 6);
        stall_next = receiver_idles && ($urandom_range(0, 99) < 40);
      end
      stall_run--;
      out_stall <= stall_next;

      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else if (++quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  logic [63:0] sim_now = '0;
  logic        slot_written [SLOTS];
  logic [63:0] slot_last_ivl [SLOTS];

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void queue_cmd(logic [2:0] op, int id, logic [63:0] ivl, logic rep,
                                    logic fnow, logic [63:0] now);
    cmd_word_t c;
    // same-period reset on a slot never added would read an unwritten period
    if (op == OP_RESET && !slot_written[id]) fnow = 1'b1;
    if (op == OP_ADD || op == OP_RESET) slot_last_ivl[id] = ivl;
    if (op == OP_ADD) slot_written[id] = 1'b1;
    c.op = op; c.id = 4'(id); c.ivl = ivl; c.rep = rep; c.fnow = fnow; c.now = now;
    cmd_backlog = {cmd_backlog, c};
  endfunction

  function automatic logic [63:0] pick_interval();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 64'($urandom_range(0, 60));
    if (r < 85) return 64'($urandom_range(0, 5000));
    if (r < 95) return rand64();
    return ALL_ONES;
  endfunction

  // time mostly creeps forward, with jumps back (small and past the window)
  function automatic logic [63:0] advance_now();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 90) sim_now += 64'($urandom_range(0, 30));
    else if (r < 95) sim_now -= 64'($urandom_range(0, 5000));
    else if (r < 98) sim_now -= 64'($urandom_range(0, 8000000));
    else sim_now = rand64();
    return sim_now;
  endfunction

  function automatic void queue_random(int unsigned count);
    int unsigned r;
    int id;
    logic [63:0] ivl;
    for (int unsigned k = 0; k < count; k++) begin
      id = $urandom_range(0, SLOTS - 1);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // fill the whole table then collect: the per-collect limit and ordering of ties
        for (int i = 0; i < SLOTS; i++)
          queue_cmd(OP_ADD, i, 64'($urandom_range(0, 3)), rand_bit(), 1'b0, sim_now);
        queue_cmd(OP_COLLECT, 0, rand64(), 1'b0, 1'b0, sim_now + 64'd10);
        k += SLOTS;
      end
      else if (r < 28) queue_cmd(OP_ADD, id, pick_interval(), rand_bit(),
                                 rand_bit(), advance_now());
      else if (r < 36) queue_cmd(OP_CANCEL, id, rand64(), rand_bit(),
                                 rand_bit(), advance_now());
      else if (r < 44) queue_cmd(OP_REFRESH, id, rand64(), rand_bit(),
                                 rand_bit(), advance_now());
      else if (r < 56) begin
        ivl = ($urandom_range(0, 3) == 0) ? slot_last_ivl[id] : pick_interval();
        queue_cmd(OP_RESET, id, ivl, rand_bit(), rand_bit(), advance_now());
      end
      else if (r < 68) queue_cmd(OP_WAIT, id, rand64(), rand_bit(),
                                 rand_bit(), advance_now());
      else if (r < 92) queue_cmd(OP_COLLECT, id, rand64(), rand_bit(),
                                 rand_bit(), advance_now());
      else if (r < 97) queue_cmd(OP_ANY, id, rand64(), rand_bit(),
                                 rand_bit(), advance_now());
      else queue_cmd(OP_UNDEF, id, rand64(), rand_bit(), rand_bit(), advance_now());
    end
  endfunction

  // register write with a setup and an access phase, taken at the access edge
  task automatic write_window(logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_WINDOW;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    tbl_window = value;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // let the backlog and all outstanding words drain, then let the block settle;
  // checked between edges so a word just popped by the driver is seen as held
  task automatic drain();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || due_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    foreach (tbl_active[i]) begin
      tbl_deadline[i] = '0; tbl_period[i] = '0; tbl_rearm[i] = 1'b0; tbl_active[i] = 1'b0;
      slot_written[i] = 1'b0; slot_last_ivl[i] = '0;
    end
    tbl_tickled = 1'b0;
    tbl_prev_now = '0;
    tbl_window = WINDOW_RST;
    n_cmds = 0; n_words = 0; n_expired = 0; n_rollovers = 0; n_mismatch = 0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: front reports, early reset, inactive slots, wait extremes,
    // rollover below the window, unknown operation
    queue_cmd(OP_ANY, 0, '0, 1'b0, 1'b0, '0);
    queue_cmd(OP_WAIT, 0, '0, 1'b0, 1'b0, '0);
    queue_cmd(OP_COLLECT, 0, '0, 1'b0, 1'b0, 64'd1);
    queue_cmd(OP_ADD, 0, '0, 1'b1, 1'b0, '0);
    queue_cmd(OP_ADD, 15, ALL_ONES, 1'b0, 1'b1, 64'd5);
    queue_cmd(OP_ADD, 3, 64'd10, 1'b0, 1'b0, 64'd5);
    queue_cmd(OP_WAIT, 0, '0, 1'b0, 1'b0, 64'd5);
    queue_cmd(OP_ADD, 3, 64'd1, 1'b1, 1'b0, '0);
    queue_cmd(OP_ANY, 0, '0, 1'b0, 1'b0, 64'd5);
    queue_cmd(OP_RESET, 3, 64'd1, 1'b0, 1'b0, 64'd6);
    queue_cmd(OP_RESET, 3, 64'd20, 1'b0, 1'b0, 64'd6);
    queue_cmd(OP_RESET, 3, 64'd7, 1'b0, 1'b1, 64'd8);
    queue_cmd(OP_REFRESH, 3, '0, 1'b0, 1'b0, 64'd9);
    queue_cmd(OP_REFRESH, 7, '0, 1'b0, 1'b0, 64'd9);
    queue_cmd(OP_CANCEL, 7, '0, 1'b0, 1'b0, 64'd9);
    queue_cmd(OP_RESET, 7, 64'd4, 1'b0, 1'b1, 64'd9);
    queue_cmd(OP_CANCEL, 15, '0, 1'b0, 1'b0, 64'd9);
    queue_cmd(OP_RESET, 15, 64'd3, 1'b0, 1'b1, 64'd9);
    queue_cmd(OP_ADD, 15, ALL_ONES, 1'b0, 1'b0, ALL_ONES);
    queue_cmd(OP_COLLECT, 0, '0, 1'b0, 1'b0, 64'd100);
    queue_cmd(OP_WAIT, 0, '0, 1'b0, 1'b0, ALL_ONES);
    queue_cmd(OP_COLLECT, 0, '0, 1'b0, 1'b0, 64'd50);
    queue_cmd(OP_UNDEF, 5, ALL_ONES, 1'b1, 1'b1, ALL_ONES);
    queue_cmd(OP_ANY, 0, '0, 1'b0, 1'b0, 64'd50);
    drain();

    // narrowest window: any step back is a rollover
    write_window(32'd0);
    sim_now = 64'd1000;
    queue_random(130);
    drain();

    // widest window, no idling on either side
    write_window(32'hFFFF_FFFF);
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    queue_random(120);
    drain();

    // mid window, near the top of the time range
    write_window(32'd2_000_000);
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    sim_now = 64'hFFFF_FFFF_FFFF_0000;
    queue_random(110);
    drain();

    $display("covered %0d commands over four window settings: %0d result words, %0d expiries",
             n_cmds, n_words, n_expired);
    $display("rollover collects seen: %0d, mismatches: %0d", n_rollovers, n_mismatch);
    if (n_mismatch == 0 && due_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
